@@ sv/epq_pkg.sv @@
// Shared constants for the edge priority queue: operation codes and default sizes.
`default_nettype none
package epq_pkg;

  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

  localparam int CAPACITY_DEF    = 64;
  localparam int VERTEX_BITS_DEF = 10;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int ENTRY_W_DEF     = 2 * VERTEX_BITS_DEF + WEIGHT_BITS_DEF;

endpackage
`default_nettype wire

@@ sv/epq_ring.sv @@
// Edge storage: one write port, one registered read port.
`default_nettype none
module epq_ring #(
  parameter int DEPTH = epq_pkg::CAPACITY_DEF,
  parameter int WIDTH = epq_pkg::ENTRY_W_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ sv/edge_priority_queue.sv @@
// Top level of the edge priority queue: sequencer, ring pointers, comparator and result register.
//
// Edges live in a ring buffer with a head pointer, so a push or a pop costs no data movement.
// A push, a rejected operation or an unused code goes from acceptance straight to the emit
// state, which loads its result into the output register. A pop reads the front entry; if
// that entry held the least weight, the remaining entries are read back one per cycle to find
// the new minimum. A sorted insert walks from the front one entry per cycle, moving each entry
// that stays ahead of the new edge one slot toward the new head, and then writes the new edge.
// The ring has a single read port and the design one shared signed comparator, so both walks
// go one entry at a time. One item is in flight at a time; in_stall is high from acceptance
// until the result is loaded into the output register.
`default_nettype none
module edge_priority_queue #(
  parameter int CAPACITY    = epq_pkg::CAPACITY_DEF,
  parameter int VERTEX_BITS = epq_pkg::VERTEX_BITS_DEF,
  parameter int WEIGHT_BITS = epq_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [epq_pkg::FUNC_W-1:0]   in_func,
  input  wire logic        [VERTEX_BITS-1:0]       in_start_vertex,
  input  wire logic        [VERTEX_BITS-1:0]       in_end_vertex,
  input  wire logic signed [WEIGHT_BITS-1:0]       in_weight,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [VERTEX_BITS-1:0]       out_start,
  output logic             [VERTEX_BITS-1:0]       out_end,
  output logic signed      [WEIGHT_BITS-1:0]       out_weight,
  output logic                                     out_popped_valid,
  output logic                                     out_rejected,
  output logic signed      [WEIGHT_BITS-1:0]       out_min_weight,
  output logic             [$clog2(CAPACITY+1)-1:0] out_entry_count
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = 2 * VERTEX_BITS + WEIGHT_BITS;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_TAIL = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_MIN  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
    return (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  logic [2:0]                    state_r, state_nxt;
  logic [IDX_W-1:0]              head_r, head_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic signed [WEIGHT_BITS-1:0] min_r, min_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic [IDX_W-1:0]              rptr_r, rptr_nxt;
  logic [IDX_W-1:0]              wptr_r, wptr_nxt;

  logic [VERTEX_BITS-1:0]        e_sv_r, e_sv_nxt;
  logic [VERTEX_BITS-1:0]        e_ev_r, e_ev_nxt;
  logic signed [WEIGHT_BITS-1:0] e_w_r, e_w_nxt;

  logic [VERTEX_BITS-1:0]        p_s_r, p_s_nxt;
  logic [VERTEX_BITS-1:0]        p_e_r, p_e_nxt;
  logic signed [WEIGHT_BITS-1:0] p_w_r, p_w_nxt;
  logic                          p_pop_r, p_pop_nxt;
  logic                          p_rej_r, p_rej_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [VERTEX_BITS-1:0]        out_s_r, out_s_nxt;
  logic [VERTEX_BITS-1:0]        out_e_r, out_e_nxt;
  logic signed [WEIGHT_BITS-1:0] out_w_r, out_w_nxt;
  logic                          out_pop_r, out_pop_nxt;
  logic                          out_rej_r, out_rej_nxt;
  logic signed [WEIGHT_BITS-1:0] out_min_r, out_min_nxt;
  logic [CNT_W-1:0]              out_cnt_r, out_cnt_nxt;

  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [ENTRY_W-1:0]            wr_data;
  logic [IDX_W-1:0]              rd_addr;
  logic [ENTRY_W-1:0]            rd_data;

  logic [VERTEX_BITS-1:0]        d_sv;
  logic [VERTEX_BITS-1:0]        d_ev;
  logic signed [WEIGHT_BITS-1:0] d_w;

  logic signed [WEIGHT_BITS-1:0] cmp_a;
  logic signed [WEIGHT_BITS-1:0] cmp_b;
  logic                          cmp_lt;
  logic                          cmp_le;
  logic                          in_accept;
  logic                          scan_stop;

  epq_ring #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign d_sv = rd_data[ENTRY_W-1 -: VERTEX_BITS];
  assign d_ev = rd_data[WEIGHT_BITS +: VERTEX_BITS];
  assign d_w  = signed'(rd_data[WEIGHT_BITS-1:0]);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // shared signed comparator
  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        cmp_a = in_weight;
        cmp_b = min_r;
      end
      ST_SCAN: begin
        cmp_a = d_w;
        cmp_b = e_w_r;
      end
      default: begin
        cmp_a = d_w;
        cmp_b = min_r;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_le = cmp_a <= cmp_b;

  // front entry: stop when new weight is at most its weight; later: when entry is heavier
  assign scan_stop = (k_r == '0) ? !cmp_lt : !cmp_le;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    k_nxt         = k_r;
    rptr_nxt      = rptr_r;
    wptr_nxt      = wptr_r;
    e_sv_nxt      = e_sv_r;
    e_ev_nxt      = e_ev_r;
    e_w_nxt       = e_w_r;
    p_s_nxt       = p_s_r;
    p_e_nxt       = p_e_r;
    p_w_nxt       = p_w_r;
    p_pop_nxt     = p_pop_r;
    p_rej_nxt     = p_rej_r;
    out_valid_nxt = out_valid_r;
    out_s_nxt     = out_s_r;
    out_e_nxt     = out_e_r;
    out_w_nxt     = out_w_r;
    out_pop_nxt   = out_pop_r;
    out_rej_nxt   = out_rej_r;
    out_min_nxt   = out_min_r;
    out_cnt_nxt   = out_cnt_r;
    wr_en         = 1'b0;
    wr_addr       = wptr_r;
    wr_data       = {e_sv_r, e_ev_r, e_w_r};
    rd_addr       = head_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = head_r;
        if (in_accept) begin
          e_sv_nxt  = in_start_vertex;
          e_ev_nxt  = in_end_vertex;
          e_w_nxt   = in_weight;
          p_s_nxt   = '0;
          p_e_nxt   = '0;
          p_w_nxt   = '0;
          p_pop_nxt = 1'b0;
          p_rej_nxt = 1'b0;
          unique case (in_func)
            epq_pkg::FUNC_INSERT, epq_pkg::FUNC_PUSH: begin
              if (count_r == CAP_CNT) begin
                p_rej_nxt = 1'b1;
                state_nxt = ST_EMIT;
              end else begin
                min_nxt = (count_r == '0 || cmp_lt) ? in_weight : min_r;
                if (in_func == epq_pkg::FUNC_PUSH || count_r == '0) begin
                  wr_en     = 1'b1;
                  wr_addr   = idx_dec(head_r);
                  wr_data   = {in_start_vertex, in_end_vertex, in_weight};
                  head_nxt  = idx_dec(head_r);
                  count_nxt = count_r + CNT_W'(1);
                  state_nxt = ST_EMIT;
                end else begin
                  rptr_nxt  = head_r;
                  wptr_nxt  = idx_dec(head_r);
                  k_nxt     = '0;
                  state_nxt = ST_SCAN;
                end
              end
            end
            epq_pkg::FUNC_POP: begin
              if (count_r == '0) begin
                p_rej_nxt = 1'b1;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_POP;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        rd_addr = idx_inc(rptr_r);
        wr_en   = 1'b1;
        wr_addr = wptr_r;
        if (scan_stop) begin
          head_nxt  = idx_dec(head_r);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_EMIT;
        end else begin
          wr_data  = rd_data;
          k_nxt    = k_r + CNT_W'(1);
          rptr_nxt = idx_inc(rptr_r);
          wptr_nxt = idx_inc(wptr_r);
          if (k_r + CNT_W'(1) == count_r) begin
            state_nxt = ST_TAIL;
          end
        end
      end

      ST_TAIL: begin
        wr_en     = 1'b1;
        wr_addr   = wptr_r;
        head_nxt  = idx_dec(head_r);
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_EMIT;
      end

      ST_POP: begin
        rd_addr   = idx_inc(head_r);
        p_s_nxt   = d_sv;
        p_e_nxt   = d_ev;
        p_w_nxt   = d_w;
        p_pop_nxt = 1'b1;
        head_nxt  = idx_inc(head_r);
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          min_nxt   = '0;
          state_nxt = ST_EMIT;
        end else if (cmp_le && !cmp_lt) begin
          // front held the minimum: rescan the rest
          rptr_nxt  = idx_inc(head_r);
          k_nxt     = '0;
          state_nxt = ST_MIN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_MIN: begin
        rd_addr = idx_inc(rptr_r);
        min_nxt = (k_r == '0 || cmp_lt) ? d_w : min_r;
        if (k_r + CNT_W'(1) == count_r) begin
          state_nxt = ST_EMIT;
        end else begin
          k_nxt    = k_r + CNT_W'(1);
          rptr_nxt = idx_inc(rptr_r);
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_s_nxt     = p_s_r;
          out_e_nxt     = p_e_r;
          out_w_nxt     = p_w_r;
          out_pop_nxt   = p_pop_r;
          out_rej_nxt   = p_rej_r;
          out_min_nxt   = min_r;
          out_cnt_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    rptr_r    <= rptr_nxt;
    wptr_r    <= wptr_nxt;
    e_sv_r    <= e_sv_nxt;
    e_ev_r    <= e_ev_nxt;
    e_w_r     <= e_w_nxt;
    p_s_r     <= p_s_nxt;
    p_e_r     <= p_e_nxt;
    p_w_r     <= p_w_nxt;
    p_pop_r   <= p_pop_nxt;
    p_rej_r   <= p_rej_nxt;
    out_s_r   <= out_s_nxt;
    out_e_r   <= out_e_nxt;
    out_w_r   <= out_w_nxt;
    out_pop_r <= out_pop_nxt;
    out_rej_r <= out_rej_nxt;
    out_min_r <= out_min_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_start        = out_s_r;
  assign out_end          = out_e_r;
  assign out_weight       = out_w_r;
  assign out_popped_valid = out_pop_r;
  assign out_rejected     = out_rej_r;
  assign out_min_weight   = out_min_r;
  assign out_entry_count  = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted item did not start work");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_popped_valid && out_rejected))
    else $error("pop and reject flagged together");

  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == '0 |-> out_min_weight == '0)
    else $error("empty store reports nonzero minimum");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the edge priority queue: directed and random operation streams.
module tb;

  localparam int CAP = epq_pkg::CAPACITY_DEF;
  localparam int VB = epq_pkg::VERTEX_BITS_DEF;
  localparam int WB = epq_pkg::WEIGHT_BITS_DEF;
  localparam int CW = $clog2(CAP + 1);
  localparam int FW = epq_pkg::FUNC_W;
  localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = CAP + 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [VB-1:0]        start_v;
    logic [VB-1:0]        end_v;
    logic signed [WB-1:0] wt;
    logic                 popped;
    logic                 rej;
    logic signed [WB-1:0] min_w;
    logic [CW-1:0]        count;
  } edge_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 out_stall = 1'b0;
  logic [FW-1:0]        in_func = '0;
  logic [VB-1:0]        in_start_vertex = '0;
  logic [VB-1:0]        in_end_vertex = '0;
  logic signed [WB-1:0] in_weight = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [VB-1:0]        out_start;
  logic [VB-1:0]        out_end;
  logic signed [WB-1:0] out_weight;
  logic                 out_popped_valid;
  logic                 out_rejected;
  logic signed [WB-1:0] out_min_weight;
  logic [CW-1:0]        out_entry_count;

  logic [VB-1:0]        pq_start [CAP];
  logic [VB-1:0]        pq_end [CAP];
  logic signed [WB-1:0] pq_weight [CAP];
  int                   pq_count = 0;

  edge_result_t pending_results [$];

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int n_results = 0;
  int n_insert = 0;
  int n_push = 0;
  int n_pop = 0;
  int n_unused = 0;
  int n_reject = 0;
  int max_fill = 0;

  edge_priority_queue #(
    .CAPACITY(CAP),
    .VERTEX_BITS(VB),
    .WEIGHT_BITS(WB)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_start_vertex(in_start_vertex),
    .in_end_vertex(in_end_vertex),
    .in_weight(in_weight),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_start(out_start),
    .out_end(out_end),
    .out_weight(out_weight),
    .out_popped_valid(out_popped_valid),
    .out_rejected(out_rejected),
    .out_min_weight(out_min_weight),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic edge_result_t predict_queue_op(input logic [FW-1:0] f,
                                                    input logic [VB-1:0] sv,
                                                    input logic [VB-1:0] ev,
                                                    input logic signed [WB-1:0] w);
    edge_result_t r;
    int pos;
    int i;
    r.start_v = '0;
    r.end_v = '0;
    r.wt = '0;
    r.popped = 1'b0;
    r.rej = 1'b0;
    r.min_w = '0;
    case (f)
      epq_pkg::FUNC_INSERT, epq_pkg::FUNC_PUSH: begin
        if (pq_count >= CAP) begin
          r.rej = 1'b1;
        end else begin
          if (f == epq_pkg::FUNC_PUSH || pq_count == 0 || w <= pq_weight[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < pq_count && pq_weight[pos] <= w) pos++;
          end
          for (i = pq_count; i > pos; i--) begin
            pq_start[i] = pq_start[i-1];
            pq_end[i] = pq_end[i-1];
            pq_weight[i] = pq_weight[i-1];
          end
          pq_start[pos] = sv;
          pq_end[pos] = ev;
          pq_weight[pos] = w;
          pq_count++;
        end
      end
      epq_pkg::FUNC_POP: begin
        if (pq_count == 0) begin
          r.rej = 1'b1;
        end else begin
          r.start_v = pq_start[0];
          r.end_v = pq_end[0];
          r.wt = pq_weight[0];
          r.popped = 1'b1;
          for (i = 1; i < pq_count; i++) begin
            pq_start[i-1] = pq_start[i];
            pq_end[i-1] = pq_end[i];
            pq_weight[i-1] = pq_weight[i];
          end
          pq_count--;
        end
      end
      default: begin
      end
    endcase
    if (pq_count > 0) begin
      r.min_w = pq_weight[0];
      for (i = 1; i < pq_count; i++)
        if (pq_weight[i] < r.min_w) r.min_w = pq_weight[i];
    end
    r.count = CW'(pq_count);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             n_results, name, got, exp_val));
  endtask

  always @(posedge clk) begin : result_check
    edge_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with no item pending", n_results));
      end else begin
        e = pending_results.pop_front();
        check_field("out_start", out_start, e.start_v);
        check_field("out_end", out_end, e.end_v);
        check_field("out_weight", out_weight, e.wt);
        check_field("out_popped_valid", out_popped_valid, e.popped);
        check_field("out_rejected", out_rejected, e.rej);
        check_field("out_min_weight", out_min_weight, e.min_w);
        check_field("out_entry_count", out_entry_count, e.count);
      end
      n_results++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_item(input logic [FW-1:0] f, input logic [VB-1:0] sv,
                           input logic [VB-1:0] ev, input logic signed [WB-1:0] w);
    edge_result_t r;
    @(negedge clk);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_start_vertex <= sv;
    in_end_vertex <= ev;
    in_weight <= w;
    do @(posedge clk); while (in_stall);
    r = predict_queue_op(f, sv, ev, w);
    pending_results.push_back(r);
    case (f)
      epq_pkg::FUNC_INSERT: n_insert++;
      epq_pkg::FUNC_PUSH:   n_push++;
      epq_pkg::FUNC_POP:    n_pop++;
      default:              n_unused++;
    endcase
    if (r.rej) n_reject++;
    if (pq_count > max_fill) max_fill = pq_count;
  endtask

  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ins_pct sets the share of inserts and pushes, which steers the fill level
  task automatic random_item(input int ins_pct, output logic [FW-1:0] f,
                             output logic [VB-1:0] sv, output logic [VB-1:0] ev,
                             output logic signed [WB-1:0] w);
    int r;
    r = $urandom_range(99);
    if (r < 4)
      f = FUNC_UNUSED;
    else if (r < ins_pct)
      f = ($urandom_range(3) == 0) ? epq_pkg::FUNC_PUSH : epq_pkg::FUNC_INSERT;
    else
      f = epq_pkg::FUNC_POP;
    sv = VB'($urandom);
    ev = VB'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: w = WB'($urandom_range(16) - 8);
      8, 9: begin
        case ($urandom_range(3))
          0: w = {1'b1, {(WB-1){1'b0}}};
          1: w = {1'b0, {(WB-1){1'b1}}};
          2: w = '1;
          default: w = '0;
        endcase
      end
      default: w = WB'($urandom);
    endcase
  endtask

  task automatic test_directed();
    in_idle_pct = 37;
    out_idle_pct = 69;
    send_item(epq_pkg::FUNC_POP, '0, '0, '0);
    send_item(FUNC_UNUSED, '1, '1, '1);
    send_item(epq_pkg::FUNC_INSERT, '0, '0, '0);
    send_item(epq_pkg::FUNC_INSERT, '1, '1, {1'b0, {(WB-1){1'b1}}});
    send_item(epq_pkg::FUNC_INSERT, 10'd5, 10'd6, {1'b1, {(WB-1){1'b0}}});
    send_item(epq_pkg::FUNC_INSERT, 10'd7, 10'd8, '0);
    send_item(epq_pkg::FUNC_INSERT, 10'd9, 10'd10, {1'b1, {(WB-1){1'b0}}});
    send_item(epq_pkg::FUNC_PUSH, 10'h2aa, 10'h155, {1'b0, {(WB-1){1'b1}}});
    send_item(epq_pkg::FUNC_INSERT, 10'h155, 10'h2aa, 16'sd100);
    send_item(epq_pkg::FUNC_INSERT, 10'd1, 10'd2, 16'sd100);
    send_item(epq_pkg::FUNC_INSERT, 10'd3, 10'd4, 16'sd50);
    send_item(FUNC_UNUSED, 10'd11, 10'd12, 16'sd13);
    send_item(epq_pkg::FUNC_POP, '1, '1, '1);
    send_item(epq_pkg::FUNC_POP, '0, '0, '0);
    send_item(epq_pkg::FUNC_PUSH, 10'd20, 10'd21, -16'sd1);
    send_item(epq_pkg::FUNC_INSERT, 10'd22, 10'd23, 16'sd1);
    repeat (9) send_item(epq_pkg::FUNC_POP, '0, '0, '0);
    drain_wait();
  endtask

  task automatic test_random(input int n, input int in_pct, input int out_pct);
    logic [FW-1:0] f;
    logic [VB-1:0] sv;
    logic [VB-1:0] ev;
    logic signed [WB-1:0] w;
    int left;
    int seg;
    int ins_pct;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(120, 40);
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      while (seg > 0 && left > 0) begin
        random_item(ins_pct, f, sv, ev, w);
        send_item(f, sv, ev, w);
        seg--;
        left--;
      end
    end
    drain_wait();
  endtask

  task automatic test_output_hold();
    logic [FW-1:0] f;
    logic [VB-1:0] sv;
    logic [VB-1:0] ev;
    logic signed [WB-1:0] w;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (30) begin
      random_item(60, f, sv, ev, w);
      send_item(f, sv, ev, w);
    end
    drain_wait();
  endtask

  task automatic test_sender_pause();
    logic [FW-1:0] f;
    logic [VB-1:0] sv;
    logic [VB-1:0] ev;
    logic signed [WB-1:0] w;
    in_idle_pct = 0;
    out_idle_pct = 30;
    repeat (25) begin
      random_item(80, f, sv, ev, w);
      send_item(f, sv, ev, w);
    end
    drain_wait();
    repeat (25) begin
      random_item(30, f, sv, ev, w);
      send_item(f, sv, ev, w);
    end
    drain_wait();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(420, 37, 69);
    test_random(420, 69, 37);
    test_random(380, 0, 0);
    test_output_hold();
    test_sender_pause();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("Run covered %0d items: %0d sorted inserts, %0d pushes, %0d pops, %0d unused codes",
             n_insert + n_push + n_pop + n_unused, n_insert, n_push, n_pop, n_unused);
    $display("%0d results checked, %0d rejections, fullest store %0d of %0d entries",
             n_results, n_reject, max_fill, CAP);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
